@@ hw/rtl/hbp_pkg.sv @@
// hbp_pkg: shared constants, item types and table port types for the bit packer
// no dependencies; imported by hbp_table, hbp_packer and huffman_table_bit_packer_top
package hbp_pkg;

    // table geometry and code limits
    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 24;
    localparam int CODE_W       = 24;
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int FUNC_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int CNT_W        = 3;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int TOT_W        = $clog2(ACC_W + 1);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    // input item
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_item;

    // one code table entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

    // table read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_tbl_rd;

endpackage

@@ hw/rtl/hbp_table.sv @@
// hbp_table: code table memory, one write and one registered read per cycle
// per-entry valid bits make unwritten entries read as zero after reset; uses hbp_pkg
module hbp_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hbp_pkg::t_tbl_wr i_wr,
    input  hbp_pkg::t_tbl_rd i_rd,
    output hbp_pkg::t_entry o_rd_data
);
    import hbp_pkg::*;

    t_entry                 r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_valid;

    // memory array, synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    // an entry never written reads as zero length
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hw/rtl/hbp_packer.sv @@
// hbp_packer: command sequencer, pending bit buffer and byte emitter
// drives the code table through hbp_table request structs; uses hbp_pkg
module hbp_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hbp_pkg::t_in_item i_item,
    output logic              busy,
    output hbp_pkg::t_tbl_wr  o_wr,
    output hbp_pkg::t_tbl_rd  o_rd,
    input  hbp_pkg::t_entry   i_rd_data,
    output logic              o_strobe,
    output hbp_pkg::t_out_item o_result
);
    import hbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [PEND_W-1:0] r_pend_bits, n_pend_bits;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic              r_strobe, n_strobe;
    t_out_item         r_result, n_result;

    logic              w_accept;
    logic              w_in_range;
    logic [LEN_W-1:0]  w_load_len;
    logic [CODE_W-1:0] w_load_mask;
    logic [ACC_W-1:0]  w_lk_acc;
    logic [TOT_W-1:0]  w_lk_total;
    logic [ACC_W-1:0]  w_shifted;
    logic [TOT_W-1:0]  w_rem;
    logic [BYTE_W-1:0] w_flush_byte;

    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_in_range = ({1'b0, i_item.symbol} < (SYM_W + 1)'(TABLE_DEPTH));

    // load entry: clamp the length and drop code bits above it
    assign w_load_len  = (i_item.code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                               : i_item.code_len;
    assign w_load_mask = CODE_W'(((CODE_W + 1)'(1) << w_load_len) - (CODE_W + 1)'(1));

    always_comb begin
        o_wr.en          = w_accept && (i_item.func == FUNC_LOAD) && w_in_range;
        o_wr.addr        = i_item.symbol[IDX_W-1:0];
        o_wr.entry.len   = w_load_len;
        o_wr.entry.code  = i_item.code_bits & w_load_mask;
        o_rd.en          = w_accept && (i_item.func == FUNC_ENCODE) && w_in_range;
        o_rd.addr        = i_item.symbol[IDX_W-1:0];
    end

    // append looked-up code below the pending bits
    assign w_lk_acc   = (ACC_W'(r_pend_bits) << i_rd_data.len) | ACC_W'(i_rd_data.code);
    assign w_lk_total = TOT_W'(r_pend_cnt) + TOT_W'(i_rd_data.len);

    // next byte comes from the top of the remaining bits
    assign w_rem     = r_total - TOT_W'(BYTE_W);
    assign w_shifted = r_acc >> w_rem;

    // partial byte left aligned, zero padded
    assign w_flush_byte = BYTE_W'({1'b0, r_pend_bits} << (4'(BYTE_W) - {1'b0, r_pend_cnt}));

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_total     = r_total;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_strobe    = 1'b0;
        n_result    = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_item.func)
                        FUNC_ENCODE: begin
                            if (w_in_range) begin
                                n_state = ST_LOOKUP;
                            end
                        end
                        FUNC_FLUSH: begin
                            if (r_pend_cnt != '0) begin
                                n_acc   = ACC_W'(w_flush_byte);
                                n_total = TOT_W'(BYTE_W);
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (i_rd_data.len == '0) begin
                    n_state = ST_IDLE;
                end else if (w_lk_total < TOT_W'(BYTE_W)) begin
                    n_pend_bits = PEND_W'(w_lk_acc);
                    n_pend_cnt  = w_lk_total[CNT_W-1:0];
                    n_state     = ST_IDLE;
                end else begin
                    n_acc   = w_lk_acc;
                    n_total = w_lk_total;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_strobe          = 1'b1;
                n_result.out_byte = w_shifted[BYTE_W-1:0];
                n_result.last     = (w_rem < TOT_W'(BYTE_W));
                n_total           = w_rem;
                if (w_rem < TOT_W'(BYTE_W)) begin
                    n_pend_bits = PEND_W'(r_acc)
                                  & PEND_W'((8'(1) << w_rem[CNT_W-1:0]) - 8'(1));
                    n_pend_cnt  = w_rem[CNT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_strobe    <= n_strobe;
        end
        r_acc    <= n_acc;
        r_total  <= n_total;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hw/rtl/huffman_table_bit_packer_top.sv @@
// huffman_table_bit_packer_top: code table plus sequencer that packs codes into bytes
// instantiates hbp_table and hbp_packer; uses hbp_pkg
// sequence: an encode reads the table, then strobes its bytes one per cycle; a flush of pending
// bits goes straight to the byte emitter; a new item is taken only when idle, so the rate is limited by
// table read and the single byte emitter; results cannot be stalled by the receiver
// reset: synchronous active low, clears the pending buffer and all table valid bits at once
module huffman_table_bit_packer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  hbp_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output hbp_pkg::t_out_item o_result
);
    import hbp_pkg::*;

    t_tbl_wr w_wr;
    t_tbl_rd w_rd;
    t_entry  w_rd_data;

    // code table memory
    hbp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // sequencer and byte emitter
    hbp_packer u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_item    (i_item),
        .busy      (busy),
        .o_wr      (w_wr),
        .o_rd      (w_rd),
        .i_rd_data (w_rd_data),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    // bytes of one item come back to back until the last one
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("result burst broken before last byte");

    // no new item is taken in the middle of a burst
    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("block idle while bytes remain");

    // a table load produces no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.func == FUNC_LOAD)) |=> !o_strobe)
        else $error("result after table load");
`endif

endmodule

@@ test/hbp_packer_checker.sv @@
// hbp_packer_checker: watches the item and byte channels of the bit packer, keeps
// its own code table and pending bit buffer, and compares each emitted byte in order
// depends on hbp_pkg for the item types and the function codes
`timescale 1ns / 1ps

module hbp_packer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  hbp_pkg::t_in_item  i_item,
    input  logic               i_strobe,
    input  hbp_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending_bytes
);
    import hbp_pkg::*;

    // shadow code table and pending bit buffer
    logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
    logic [PEND_W-1:0] held_bits;
    logic [CNT_W-1:0]  held_count;

    // bytes still to come, oldest first
    t_out_item byte_queue [$];

    // low n bits set, n up to the code width
    function automatic logic [CODE_W-1:0] code_mask(input int n);
        return (n >= CODE_W) ? '1 : CODE_W'((1 << n) - 1);
    endfunction

    // apply one accepted item to the shadow state and queue the bytes it emits
    task automatic pack_item(input t_in_item item);
        logic [LEN_W-1:0] len;
        logic [ACC_W-1:0] acc;
        int               total;
        int               n;
        t_out_item        res;
        case (item.func)
            FUNC_LOAD: begin
                if (int'(item.symbol) < TABLE_DEPTH) begin
                    // overlong lengths clamp, excess code bits drop
                    len = (item.code_len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : item.code_len;
                    len_mem[item.symbol]  = len;
                    code_mem[item.symbol] = item.code_bits & code_mask(len);
                end
            end
            FUNC_ENCODE: begin
                if (int'(item.symbol) < TABLE_DEPTH && len_mem[item.symbol] != '0) begin
                    len   = len_mem[item.symbol];
                    acc   = (ACC_W'(held_bits) << len)
                          | ACC_W'(code_mem[item.symbol] & code_mask(len));
                    total = int'(held_count) + int'(len);
                    n     = 0;
                    // whole bytes, earliest bits first
                    while (total >= BYTE_W && n < 3) begin
                        total        = total - BYTE_W;
                        res.out_byte = BYTE_W'(acc >> total);
                        res.last     = !(total >= BYTE_W && n + 1 < 3);
                        byte_queue.push_back(res);
                        n++;
                    end
                    held_bits  = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
                    held_count = CNT_W'(total);
                end
            end
            FUNC_FLUSH: begin
                // partial byte, zero padded in the low bits
                if (held_count != '0) begin
                    res.out_byte = BYTE_W'(held_bits) << (BYTE_W - int'(held_count));
                    res.last     = 1'b1;
                    byte_queue.push_back(res);
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    // compare emitted bytes first, then predict from the item accepted at this edge
    always @(posedge i_clk) begin
        t_out_item exp_byte;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                code_mem[k] = '0;
                len_mem[k]  = '0;
            end
            held_bits  = '0;
            held_count = '0;
            byte_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_strobe) begin
                if (byte_queue.size() == 0) begin
                    $error("byte %02h with no byte predicted", i_result.out_byte);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_byte = byte_queue.pop_front();
                    if (i_result.out_byte !== exp_byte.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               exp_byte.out_byte, i_result.out_byte);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_result.last !== exp_byte.last) begin
                        $error("last: expected %0b, got %0b", exp_byte.last, i_result.last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pack_item(i_item);
            end
        end
        o_pending_bytes = byte_queue.size();
    end

endmodule

@@ test/huffman_table_bit_packer_top_tb.sv @@
// huffman_table_bit_packer_top_tb: drives load, encode and flush items into the packer
// with random gaps; depends on hbp_pkg, huffman_table_bit_packer_top and hbp_packer_checker
`timescale 1ns / 1ps

module huffman_table_bit_packer_top_tb;
    import hbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 180;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;
    int        fail_count;
    int        pending_bytes;
    int        cycle_count;

    huffman_table_bit_packer_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    hbp_packer_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_strobe        (o_strobe),
        .i_result        (o_result),
        .o_fail_count    (fail_count),
        .o_pending_bytes (pending_bytes)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [FUNC_W-1:0] func,
                                           input logic [SYM_W-1:0] symbol,
                                           input logic [CODE_W-1:0] code_bits,
                                           input logic [LEN_W-1:0] code_len);
        t_in_item item;
        item.func      = func;
        item.symbol    = symbol;
        item.code_bits = code_bits;
        item.code_len  = code_len;
        return item;
    endfunction

    // symbols mostly from a small working set so encodes hit loaded entries
    function automatic logic [SYM_W-1:0] pick_symbol();
        return ($urandom_range(4) == 0) ? SYM_W'($urandom_range(255))
                                        : SYM_W'($urandom_range(15));
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       pick;
        pick           = $urandom_range(99);
        item.symbol    = pick_symbol();
        item.code_bits = CODE_W'($urandom());
        item.code_len  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(31))
                                                  : LEN_W'($urandom_range(1, 24));
        if (pick < 16)
            item.func = FUNC_LOAD;
        else if (pick < 80)
            item.func = FUNC_ENCODE;
        else if (pick < 95)
            item.func = FUNC_FLUSH;
        else
            item.func = FUNC_SPARE;
        return item;
    endfunction

    // present one item, hold it until accepted, then maybe leave a random idle gap
    task automatic issue_item(input t_in_item item, input bit no_gaps);
        start  <= 1'b1;
        i_item <= item;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        if (!no_gaps && $urandom_range(99) < 24) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // stop sending until every predicted byte has come out
    task automatic wait_bytes_out();
        start <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (pending_bytes == 0) break;
        end
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unused symbol, empty flush, spare function on an empty table
        issue_item(make_item(FUNC_ENCODE, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_FLUSH, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_SPARE, 8'hff, 24'hffffff, 5'd31), 1'b0);
        // directed loads: longest code, shortest code, overlong lengths, excess bits
        issue_item(make_item(FUNC_LOAD, 8'd0, 24'hffffff, 5'd24), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd255, 24'h000000, 5'd1), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd1, 24'ha5a5a5, 5'd31), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd5, 24'h123456, 5'd25), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd2, 24'habcdef, 5'd3), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd3, 24'hffffff, 5'd0), 1'b0);
        issue_item(make_item(FUNC_LOAD, 8'd4, 24'h000055, 5'd7), 1'b0);
        // directed encodes across byte boundaries
        issue_item(make_item(FUNC_ENCODE, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd255, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd1, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd2, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd3, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd4, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd5, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_FLUSH, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_FLUSH, 8'd0, 24'h0, 5'd0), 1'b0);
        // seven pending bits then longest code: three bytes with a full buffer
        issue_item(make_item(FUNC_ENCODE, 8'd4, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_ENCODE, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_FLUSH, 8'd0, 24'h0, 5'd0), 1'b0);
        issue_item(make_item(FUNC_SPARE, 8'h00, 24'h000000, 5'd0), 1'b0);

        // fill the working set of the table
        for (int k = 0; k < 16; k++) begin
            issue_item(make_item(FUNC_LOAD, SYM_W'(k), CODE_W'($urandom()),
                                 LEN_W'($urandom_range(1, 24))), 1'b0);
        end

        // random mix, with a stretch of back-to-back items and one full drain
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 110) wait_bytes_out();
            issue_item(random_item(), k >= 50 && k < 100);
        end

        // drain and let the pipeline settle
        wait_bytes_out();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
